// ----- sv/mmdet_pkg.sv -----
// ----------------------------------------------------------------------------
// mmdet_pkg: shared types and codes of the masked max distance entry table
// opcodes, table entry layout, query bundle and default depth
// ----------------------------------------------------------------------------
package mmdet_pkg;

    // default number of table entries
    localparam int unsigned TABLE_DEPTH_DEF = 64;

    // operation codes
    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_PUSH      = 3'd1;
    localparam logic [2:0] OP_FIND      = 3'd2;
    localparam logic [2:0] OP_FIND_ATTR = 3'd3;
    localparam logic [2:0] OP_SET_FIELD = 3'd4;

    // one stored hit entry
    typedef struct packed {
        logic        [31:0] types;
        logic        [15:0] attribute;
        logic signed [31:0] distance;
    } t_entry;

    // query for the shared compare unit
    typedef struct packed {
        logic [31:0] types;
        logic [31:0] attrs;
        logic        use_attr;
    } t_query;

    // running selection seen by the compare unit
    typedef struct packed {
        logic               valid;
        logic signed [31:0] distance;
    } t_best;

endpackage

// ----- sv/mmdet_ifs.sv -----
// ----------------------------------------------------------------------------
// mmdet channel interfaces
// request and result channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface mmdet_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  opcode;
    logic signed [31:0] dist_req;
    logic        [31:0] type_bits;
    logic        [31:0] attr_bits;
    logic        [15:0] field_value;
    logic        [3:0]  field_shift;
    logic        [15:0] field_mask;

    modport source (output valid, opcode, dist_req, type_bits, attr_bits,
                    field_value, field_shift, field_mask, input ready);
    modport sink   (input valid, opcode, dist_req, type_bits, attr_bits,
                    field_value, field_shift, field_mask, output ready);
endinterface

interface mmdet_res_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic        [5:0]  best_index;
    logic signed [31:0] best_dist;
    logic        [15:0] best_attribute;
    logic        [31:0] accumulated_types;
    logic        [6:0]  entry_count;

    modport source (output valid, found, best_index, best_dist, best_attribute,
                    accumulated_types, entry_count, input ready);
    modport sink   (input valid, found, best_index, best_dist, best_attribute,
                    accumulated_types, entry_count, output ready);
endinterface

// ----- sv/masked_max_distance_entry_table.sv -----
// ----------------------------------------------------------------------------
// masked_max_distance_entry_table: hit entry table with masked max search
// clear, push, find by type, find by type and attribute, set field
// ----------------------------------------------------------------------------
//
//  channel   dir  port     payload
//  --------  ---  -------  ---------------------------------------------------
//  request   in   i_req    opcode, dist_req, type_bits, attr_bits,
//                          field_value, field_shift, field_mask
//  result    out  o_res    found, best_index, best_dist, best_attribute,
//                          accumulated_types, entry_count
//
//  every request gives exactly one result
//  clear, push, unused codes and find or set field on an empty table go
//  from idle to fetch and result; set field reads and writes back the last
//  entry first; find first scans the filled entries, one entry per cycle
//  through the single read port of the entry memory, then passes scan end
//  a new request is taken only in idle; a waiting result sits in the output
//  register while the next request runs, and a stalled result holds the
//  sequencer in its last state
//  synchronous active-low reset clears control state; the entry memory is
//  not cleared, entry_count bounds what is ever read
//
module masked_max_distance_entry_table
    import mmdet_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mmdet_req_if.sink   i_req,
    mmdet_res_if.source o_res
);
    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_RMW_RD   = 3'd3;
    localparam logic [2:0] ST_RMW_WR   = 3'd4;
    localparam logic [2:0] ST_FETCH    = 3'd5;
    localparam logic [2:0] ST_RESULT   = 3'd6;

    // control state
    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [31:0]        r_acc, n_acc;
    logic               r_best_valid, n_best_valid;
    logic [IW-1:0]      r_best_slot, n_best_slot;
    logic signed [31:0] r_best_dist, n_best_dist;
    logic [IW-1:0]      r_idx, n_idx;
    logic [IW-1:0]      r_pend_idx;
    logic               r_pend;
    logic               r_out_valid, n_out_valid;

    // latched request fields
    t_query             r_query;
    logic [15:0]        r_fval;
    logic [3:0]         r_fshift;
    logic [15:0]        r_fmask;

    // entry memory, one write and one read port, registered read data
    t_entry             r_entries [TABLE_DEPTH];
    t_entry             r_rd_data;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    t_entry             wr_data;

    // result register
    logic               r_found;
    logic [5:0]         r_index;
    logic signed [31:0] r_dist;
    logic [15:0]        r_attr;
    logic [31:0]        r_acc_out;
    logic [6:0]         r_count_out;

    logic               accept;
    logic               out_free;
    logic               take;
    logic               table_full;
    logic               scan_last;
    t_best              best_now;
    t_entry             rmw_entry;

    assign accept     = i_req.valid && i_req.ready;
    assign out_free   = !r_out_valid || o_res.ready;
    assign table_full = r_count == CW'(TABLE_DEPTH);
    // last entry address of a scan
    assign scan_last  = CW'(r_idx) == (r_count - CW'(1));

    assign i_req.ready = r_state == ST_IDLE;

    // shared compare unit, fed by the registered read data during a scan
    assign best_now.valid    = r_best_valid;
    assign best_now.distance = r_best_dist;

    mmdet_cmp u_cmp (
        .i_entry (r_rd_data),
        .i_query (r_query),
        .i_best  (best_now),
        .o_take  (take)
    );

    // set field: clear masked bits, or in shifted value
    always_comb begin
        rmw_entry           = r_rd_data;
        rmw_entry.attribute = (r_rd_data.attribute & ~r_fmask) | 16'(r_fval << r_fshift);
    end

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_best_slot;
        wr_en   = 1'b0;
        wr_addr = IW'(r_count - CW'(1));
        wr_data = rmw_entry;
        case (r_state)
            ST_IDLE: begin
                // push writes straight from the request
                if (accept && i_req.opcode == OP_PUSH) begin
                    wr_en             = 1'b1;
                    wr_addr           = table_full ? IW'(TABLE_DEPTH - 1) : IW'(r_count);
                    wr_data.types     = i_req.type_bits;
                    wr_data.attribute = i_req.attr_bits[15:0];
                    wr_data.distance  = i_req.dist_req;
                end
            end
            ST_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
            end
            ST_RMW_RD: begin
                rd_en   = 1'b1;
                rd_addr = IW'(r_count - CW'(1));
            end
            ST_RMW_WR: begin
                wr_en = 1'b1;
            end
            ST_FETCH: begin
                rd_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_entries[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_entries[rd_addr];
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_acc        = r_acc;
        n_best_valid = r_best_valid;
        n_best_slot  = r_best_slot;
        n_best_dist  = r_best_dist;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !o_res.ready;

        // compare result of the entry read in the previous cycle
        if (r_pend && take) begin
            n_best_valid = 1'b1;
            n_best_slot  = r_pend_idx;
            n_best_dist  = r_rd_data.distance;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_FETCH;
                    case (i_req.opcode)
                        OP_CLEAR: begin
                            n_count      = '0;
                            n_acc        = '0;
                            n_best_valid = 1'b0;
                            n_best_slot  = '0;
                        end
                        OP_PUSH: begin
                            n_acc = r_acc | i_req.type_bits;
                            if (!table_full) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_FIND, OP_FIND_ATTR: begin
                            n_best_valid = 1'b0;
                            n_best_slot  = '0;
                            n_idx        = '0;
                            if (r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_SET_FIELD: begin
                            // ignored on an empty table
                            if (r_count != '0) begin
                                n_state = ST_RMW_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + IW'(1);
                if (scan_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_FETCH;
            end
            ST_RMW_RD: begin
                n_state = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                n_state = ST_FETCH;
            end
            ST_FETCH: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_acc        <= '0;
            r_best_valid <= 1'b0;
            r_best_slot  <= '0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_acc        <= n_acc;
            r_best_valid <= n_best_valid;
            r_best_slot  <= n_best_slot;
            r_idx        <= n_idx;
            r_pend       <= r_state == ST_SCAN;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_best_dist <= n_best_dist;
        r_pend_idx  <= r_idx;
        if (accept) begin
            r_query.types    <= i_req.type_bits;
            r_query.attrs    <= i_req.attr_bits;
            r_query.use_attr <= i_req.opcode == OP_FIND_ATTR;
            r_fval           <= i_req.field_value;
            r_fshift         <= i_req.field_shift;
            r_fmask          <= i_req.field_mask;
        end
        if (r_state == ST_RESULT && out_free) begin
            r_found     <= r_best_valid;
            r_index     <= r_best_valid ? 6'(r_best_slot) : 6'd0;
            r_dist      <= r_best_valid ? r_rd_data.distance : 32'sd0;
            r_attr      <= r_best_valid ? r_rd_data.attribute : 16'd0;
            r_acc_out   <= r_acc;
            r_count_out <= 7'(r_count);
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.found             = r_found;
    assign o_res.best_index        = r_index;
    assign o_res.best_dist         = r_dist;
    assign o_res.best_attribute    = r_attr;
    assign o_res.accumulated_types = r_acc_out;
    assign o_res.entry_count       = r_count_out;

`ifndef SYNTHESIS
    // a clear request empties the table and drops the selection
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.opcode == OP_CLEAR) |=>
            (r_count == '0 && r_acc == '0 && !r_best_valid))
        else $error("clear did not empty the table");

    // the scan never reads past the filled part of the table
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CW'(r_idx) < r_count))
        else $error("scan address beyond entry count");

    // a push always leaves at least one entry
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.opcode == OP_PUSH) |=> (r_count != '0))
        else $error("push left the table empty");

    // a result is only loaded when the output register is free
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> r_out_valid)
        else $error("waiting result was dropped");
`endif

endmodule

// ----- sv/mmdet_cmp.sv -----
// ----------------------------------------------------------------------------
// mmdet_cmp: entry qualify and compare unit
// decides whether one scanned entry replaces the running selection
// ----------------------------------------------------------------------------
module mmdet_cmp
    import mmdet_pkg::*;
(
    input  t_entry i_entry,
    input  t_query i_query,
    input  t_best  i_best,
    output logic   o_take
);
    logic type_hit;
    logic attr_hit;
    logic dist_ok;
    logic greater;

    assign type_hit = (i_entry.types & i_query.types) != 32'd0;
    assign attr_hit = !i_query.use_attr || i_query.attrs[i_entry.attribute[4:0]];
    // negative distances never qualify
    assign dist_ok  = !i_entry.distance[31];
    // strict compare keeps the lowest index on ties
    assign greater  = !i_best.valid || (i_entry.distance > i_best.distance);
    assign o_take   = type_hit && attr_hit && dist_ok && greater;
endmodule

// ----- tb/masked_max_distance_entry_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_max_distance_entry_table_tb: self-checking bench of the entry table
// a queue of requests feeds a clocked driver; an in-bench table model
// predicts each result, and a clocked monitor checks them in order
// ----------------------------------------------------------------------------
module masked_max_distance_entry_table_tb;
    import mmdet_pkg::*;

    localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
    localparam time         CLK_PERIOD   = 20ns;
    localparam int          RESET_CYCLES = 6;
    localparam int          IDLE_PCT     = 20;
    localparam int          RANDOM_OPS   = 500;
    // no idling on either side while the accepted request count is in [CALM_FIRST, CALM_LAST)
    localparam int          CALM_FIRST   = 150;
    localparam int          CALM_LAST    = 300;
    localparam int          DRAIN_CYCLES = DEPTH + 16;
    localparam int          CYCLE_LIMIT  = 300000;

    // codes the block treats as no operation
    localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic        [2:0]  opcode;
        logic signed [31:0] distance;
        logic        [31:0] types;
        logic        [31:0] attrs;
        logic        [15:0] fval;
        logic        [3:0]  fshift;
        logic        [15:0] fmask;
    } t_table_op;

    typedef struct packed {
        logic               found;
        logic        [5:0]  best_index;
        logic signed [31:0] best_dist;
        logic        [15:0] best_attribute;
        logic        [31:0] accumulated_types;
        logic        [6:0]  entry_count;
    } t_selection;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mmdet_req_if req_ch ();
    mmdet_res_if res_ch ();

    masked_max_distance_entry_table #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // table model: entries, fill level, type accumulator, held selection
    // ------------------------------------------------------------------------
    logic        [31:0] mdl_types [DEPTH];
    logic        [15:0] mdl_attr  [DEPTH];
    logic signed [31:0] mdl_dist  [DEPTH];
    int unsigned        mdl_count;
    logic        [31:0] mdl_acc;
    logic               mdl_sel_valid;
    int unsigned        mdl_sel_slot;

    t_table_op  queued_ops[$];
    t_selection selections_due[$];
    t_table_op  cur_op;
    logic       op_taken;
    int         ops_taken_count;
    int         fail_count;
    int         cycle_count;
    logic       calm;

    assign calm = (ops_taken_count >= CALM_FIRST) && (ops_taken_count < CALM_LAST);

    function automatic t_selection apply_table_op(t_table_op op);
        t_selection  sel;
        longint      top;
        logic [15:0] shifted;
        int unsigned slot;
        case (op.opcode)
            OP_CLEAR: begin
                mdl_count     = 0;
                mdl_acc       = '0;
                mdl_sel_valid = 1'b0;
                mdl_sel_slot  = 0;
            end
            OP_PUSH: begin
                mdl_acc = mdl_acc | op.types;
                // full table: the last slot is overwritten
                if (mdl_count >= DEPTH) begin
                    mdl_count = DEPTH - 1;
                end
                slot            = mdl_count;
                mdl_types[slot] = op.types;
                mdl_attr[slot]  = op.attrs[15:0];
                mdl_dist[slot]  = op.distance;
                mdl_count++;
            end
            OP_FIND, OP_FIND_ATTR: begin
                mdl_sel_valid = 1'b0;
                mdl_sel_slot  = 0;
                top           = -1;
                // strict greater-than keeps the lowest index on ties
                for (int i = 0; i < mdl_count; i++) begin
                    if ((mdl_types[i] & op.types) != 0 &&
                        (op.opcode != OP_FIND_ATTR || op.attrs[mdl_attr[i][4:0]]) &&
                        longint'(mdl_dist[i]) > top) begin
                        top           = longint'(mdl_dist[i]);
                        mdl_sel_valid = 1'b1;
                        mdl_sel_slot  = i;
                    end
                end
            end
            OP_SET_FIELD: begin
                // empty table: nothing to rewrite
                if (mdl_count > 0) begin
                    slot           = mdl_count - 1;
                    shifted        = op.fval << op.fshift;
                    mdl_attr[slot] = (mdl_attr[slot] & ~op.fmask) | shifted;
                end
            end
            default: ;
        endcase

        // held selection reads the table as it stands after this request
        sel = '0;
        if (mdl_sel_valid) begin
            sel.found          = 1'b1;
            sel.best_index     = mdl_sel_slot[5:0];
            sel.best_dist      = mdl_dist[mdl_sel_slot];
            sel.best_attribute = mdl_attr[mdl_sel_slot];
        end
        sel.accumulated_types = mdl_acc;
        sel.entry_count       = mdl_count[6:0];
        return sel;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_op(input logic [2:0] opcode, input logic [31:0] distance,
                          input logic [31:0] types, input logic [31:0] attrs,
                          input logic [15:0] fval, input logic [3:0] fshift,
                          input logic [15:0] fmask);
        t_table_op op;
        op.opcode   = opcode;
        op.distance = distance;
        op.types    = types;
        op.attrs    = attrs;
        op.fval     = fval;
        op.fshift   = fshift;
        op.fmask    = fmask;
        queued_ops.push_back(op);
    endtask

    // sparse masks so that finds both hit and miss
    function automatic logic [31:0] pick_types();
        case ($urandom_range(0, 7))
            0, 1:    return 32'h1 << $urandom_range(0, 31);
            2:       return (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 31));
            3:       return $urandom;
            4:       return '1;
            5, 6:    return 32'h1 << $urandom_range(0, 3);
            default: return '0;
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // request driver: new payload at the falling edge once the last one went in
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || op_taken) begin
            if (queued_ops.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                cur_op = queued_ops.pop_front();
                req_ch.opcode      <= cur_op.opcode;
                req_ch.dist_req    <= cur_op.distance;
                req_ch.type_bits   <= cur_op.types;
                req_ch.attr_bits   <= cur_op.attrs;
                req_ch.field_value <= cur_op.fval;
                req_ch.field_shift <= cur_op.fshift;
                req_ch.field_mask  <= cur_op.fmask;
                req_ch.valid       <= 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // accepted request: run it through the table model
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_taken <= 1'b0;
        end else begin
            op_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready) begin
                selections_due.push_back(apply_table_op(cur_op));
                ops_taken_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: random back-pressure, in-order check at the rising edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        res_ch.ready <= i_rst_n && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (selections_due.size() == 0) begin
                $error("result with no request waiting for it");
                fail_count++;
            end else begin
                t_selection due;
                due = selections_due.pop_front();
                compare_field("found", 64'(due.found), 64'(res_ch.found));
                compare_field("best_index", 64'(due.best_index), 64'(res_ch.best_index));
                compare_field("best_dist", 64'(due.best_dist), 64'(res_ch.best_dist));
                compare_field("best_attribute", 64'(due.best_attribute),
                              64'(res_ch.best_attribute));
                compare_field("accumulated_types", 64'(due.accumulated_types),
                              64'(res_ch.accumulated_types));
                compare_field("entry_count", 64'(due.entry_count), 64'(res_ch.entry_count));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int          random_done;
        int          blk_len;
        int          push_pct;
        int          pick;
        int unsigned gen_fill;
        logic        first_blk;
        logic [2:0]  opcode;
        logic [31:0] dist_val;
        logic [15:0] fmask;

        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_CLEAR;
        req_ch.dist_req    = '0;
        req_ch.type_bits   = '0;
        req_ch.attr_bits   = '0;
        req_ch.field_value = '0;
        req_ch.field_shift = '0;
        req_ch.field_mask  = '0;
        res_ch.ready       = 1'b0;
        op_taken           = 1'b0;
        ops_taken_count    = 0;
        fail_count         = 0;
        cycle_count        = 0;
        mdl_count          = 0;
        mdl_acc            = '0;
        mdl_sel_valid      = 1'b0;
        mdl_sel_slot       = 0;
        for (int i = 0; i < DEPTH; i++) begin
            mdl_types[i] = '0;
            mdl_attr[i]  = '0;
            mdl_dist[i]  = '0;
        end

        // directed: empty table, distance extremes, ties, masks, field edits
        add_op(OP_FIND,      32'h0,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 4'd0, 16'h0);
        add_op(OP_SET_FIELD, 32'h0,         32'h0,         32'h0,  16'hFFFF, 4'd0, 16'hFFFF);
        add_op(OP_PUSH,      32'h8000_0000, 32'h0000_0001, 32'h0000_0003, 16'h0, 4'd0, 16'h0);
        add_op(OP_PUSH,      32'h0,         32'h8000_0000, 32'hFFFF_001F, 16'h0, 4'd0, 16'h0);
        add_op(OP_PUSH,      32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0005, 16'h0, 4'd0, 16'h0);
        add_op(OP_PUSH,      32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000, 16'h0, 4'd0, 16'h0);
        add_op(OP_PUSH,      32'h0001_0000, 32'h0,         32'h0000_FFFF, 16'h0, 4'd0, 16'h0);
        add_op(OP_FIND,      32'h0,         32'hFFFF_FFFF, 32'h0,  16'h0,    4'd0, 16'h0);
        add_op(OP_FIND,      32'h0,         32'h0000_0001, 32'h0,  16'h0,    4'd0, 16'h0);
        add_op(OP_FIND,      32'h0,         32'h8000_0000, 32'h0,  16'h0,    4'd0, 16'h0);
        add_op(OP_FIND,      32'h0,         32'h0,         32'h0,  16'h0,    4'd0, 16'h0);
        add_op(OP_FIND_ATTR, 32'h0,         32'hFFFF_FFFF, 32'h8000_0000, 16'h0, 4'd0, 16'h0);
        add_op(OP_FIND_ATTR, 32'h0,         32'hFFFF_FFFF, 32'h0,  16'h0,    4'd0, 16'h0);
        add_op(OP_FIND_ATTR, 32'h0,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 4'd0, 16'h0);
        add_op(OP_SET_FIELD, 32'h0,         32'h0,         32'h0,  16'hFFFF, 4'd15, 16'h0);
        add_op(OP_SET_FIELD, 32'h0,         32'h0,         32'h0,  16'h0,    4'd0, 16'hFFFF);
        add_op(OP_SET_FIELD, 32'h0,         32'h0,         32'h0,  16'h00AB, 4'd4, 16'h0FF0);
        add_op(OP_FIND,      32'h0,         32'hFFFF_FFFF, 32'h0,  16'h0,    4'd0, 16'h0);
        add_op(OP_SPARE_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               16'hFFFF, 4'd15, 16'hFFFF);
        add_op(OP_SPARE_LAST, 32'h0,        32'h0,         32'h0,  16'h0,    4'd0, 16'h0);
        add_op(OP_CLEAR,     32'h0,         32'h0,         32'h0,  16'h0,    4'd0, 16'h0);
        add_op(OP_FIND,      32'h0,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 4'd0, 16'h0);

        // random: blocks that mostly start from a clear; the first one
        // is push-heavy and long enough to fill and overrun the table
        random_done = 0;
        gen_fill    = 0;
        first_blk   = 1'b1;
        while (random_done < RANDOM_OPS) begin
            blk_len  = first_blk ? 100 : $urandom_range(4, 120);
            push_pct = first_blk ? 85 : $urandom_range(25, 75);
            if (first_blk || $urandom_range(0, 9) != 0) begin
                add_op(OP_CLEAR, $urandom, $urandom, $urandom, 16'($urandom),
                       4'($urandom), 16'($urandom));
                gen_fill = 0;
                random_done++;
            end
            for (int k = 0; k < blk_len; k++) begin
                if ($urandom_range(0, 99) < push_pct) begin
                    opcode = OP_PUSH;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35) opcode = OP_FIND;
                    else if (pick < 70) opcode = OP_FIND_ATTR;
                    else if (pick < 88) opcode = OP_SET_FIELD;
                    else if (pick < 94) opcode = OP_CLEAR;
                    else opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                end
                // distances: extremes, zero, a few tie values, negatives
                case ($urandom_range(0, 5))
                    0:       dist_val = 32'h0;
                    1:       dist_val = 32'h7FFF_FFFF;
                    2:       dist_val = 32'h8000_0000;
                    3:       dist_val = 32'($urandom_range(0, 3)) << 16;
                    4:       dist_val = 32'h8000_0000 | $urandom;
                    default: dist_val = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0:       fmask = '0;
                    1:       fmask = '1;
                    default: fmask = 16'($urandom);
                endcase
                add_op(opcode, dist_val, pick_types(), $urandom, 16'($urandom),
                       4'($urandom), fmask);
                if (opcode == OP_CLEAR) begin
                    gen_fill = 0;
                end else if (opcode == OP_PUSH && gen_fill < DEPTH) begin
                    gen_fill++;
                end
                // a field edit of an empty table does nothing
                if (!(opcode == OP_SET_FIELD && gen_fill == 0)) begin
                    random_done++;
                end
            end
            first_blk = 1'b0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // wait for every request to go in and every result to come back
        do begin
            @(posedge i_clk);
        end while (queued_ops.size() != 0 || req_ch.valid || selections_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/mmdet_pkg.sv
sv/mmdet_ifs.sv
sv/mmdet_cmp.sv
sv/masked_max_distance_entry_table.sv
tb/masked_max_distance_entry_table_tb.sv
